// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define BGC_ASSERT_IMP(label, ck, rs_n, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rs_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BGC_ASSERT_NXT(label, ck, rs_n, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rs_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BGC_ASSERT_IMP(label, ck, rs_n, ante, cons)

`define BGC_ASSERT_NXT(label, ck, rs_n, ante, cons)

`endif

`endif

// ----- hw/rtl/bgc_pkg.sv -----
// shared types and constants of the button gesture classifier
`default_nettype none

package bgc_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned TIME_W     = 32;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_CLICK  = 2'd0;
    localparam kind_t KIND_DOUBLE = 2'd1;
    localparam kind_t KIND_LONG   = 2'd2;
    localparam kind_t KIND_LONGER = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CLICK_MIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_MAX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONGER_MIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONGER_MAX     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HANDLER_ENABLE = 3'd7;

    typedef struct packed {
        logic [15:0] click_min;
        logic [15:0] click_max;
        logic [15:0] long_min;
        logic [15:0] long_max;
        logic [15:0] longer_min;
        logic [15:0] longer_max;
        logic [15:0] double_window;
        logic [3:0]  handler_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        click_min:      16'd20,
        click_max:      16'd500,
        long_min:       16'd1000,
        long_max:       16'd3000,
        longer_min:     16'd3001,
        longer_max:     16'd10000,
        double_window:  16'd300,
        handler_enable: 4'd13
    };

    // one token per accepted sample: an optional pending bit to raise
    typedef struct packed {
        logic  set_valid;
        kind_t set_kind;
    } token_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bgc_if.sv -----
// handshake interfaces for the sample and gesture channels
`default_nettype none

interface bgc_sample_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

interface bgc_gesture_if;
    import bgc_pkg::*;

    logic       valid;
    logic       ready;
    logic       event_valid;
    kind_t      event_kind;
    logic [3:0] pending_mask;

    modport source (output valid, output event_valid, output event_kind,
                    output pending_mask, input ready);
    modport sink (input valid, input event_valid, input event_kind,
                  input pending_mask, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bgc_front.sv -----
// front end: tick counter, gesture state machine and hold classification
`default_nettype none

module bgc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bgc_pkg::cfg_t  cfg,
    bgc_sample_if.sink          sample,
    input  wire logic           q_full,
    output logic                push,
    output bgc_pkg::token_t     push_token
);
    import bgc_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_PRESSED   = 3'd1;
    localparam logic [2:0] ST_RELEASED  = 3'd2;
    localparam logic [2:0] ST_IDENTIFY  = 3'd3;
    localparam logic [2:0] ST_EV_CLICK  = 3'd4;
    localparam logic [2:0] ST_EV_DOUBLE = 3'd5;
    localparam logic [2:0] ST_EV_LONG   = 3'd6;
    localparam logic [2:0] ST_EV_LONGER = 3'd7;

    function automatic logic in_window(input logic [TIME_W-1:0] v,
                                       input logic [15:0] lo,
                                       input logic [15:0] hi);
        logic [TIME_W-1:0] lo_w;
        logic [TIME_W-1:0] hi_w;
        lo_w = {{(TIME_W-16){1'b0}}, lo};
        hi_w = {{(TIME_W-16){1'b0}}, hi};
        return (v >= lo_w) && (v <= hi_w);
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [TIME_W-1:0] tick_reg;
    logic [TIME_W-1:0] press_start_reg, press_start_next;
    logic [TIME_W-1:0] hold_reg, hold_next;
    logic [TIME_W-1:0] last_click_reg, last_click_next;
    logic [TIME_W-1:0] since_click;
    logic              accept;

    assign sample.ready = !q_full;
    assign accept       = sample.valid && !q_full;
    assign push         = accept;
    assign since_click  = tick_reg - last_click_reg;

    always_comb
    begin
        state_next        = state_reg;
        press_start_next  = press_start_reg;
        hold_next         = hold_reg;
        last_click_next   = last_click_reg;
        push_token        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample.button_level)
                begin
                    press_start_next = tick_reg;
                    state_next       = ST_PRESSED;
                end
            end
            ST_PRESSED:
            begin
                if (!sample.button_level)
                begin
                    hold_next  = tick_reg - press_start_reg;
                    state_next = ST_RELEASED;
                end
            end
            ST_RELEASED:
            begin
                // first matching window wins
                if (in_window(hold_reg, cfg.click_min, cfg.click_max))
                    state_next = ST_IDENTIFY;
                else if (in_window(hold_reg, cfg.long_min, cfg.long_max))
                    state_next = ST_EV_LONG;
                else if (in_window(hold_reg, cfg.longer_min, cfg.longer_max))
                    state_next = ST_EV_LONGER;
                else
                    state_next = ST_IDLE;
            end
            ST_IDENTIFY:
            begin
                if (since_click > {{(TIME_W-16){1'b0}}, cfg.double_window})
                begin
                    last_click_next = tick_reg;
                    state_next      = ST_EV_CLICK;
                end
                else
                begin
                    state_next = ST_EV_DOUBLE;
                end
            end
            ST_EV_CLICK, ST_EV_DOUBLE, ST_EV_LONG, ST_EV_LONGER:
            begin
                // event codes map onto kinds by their low bits
                push_token.set_valid = 1'b1;
                push_token.set_kind  = state_reg[1:0];
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tick_reg        <= '0;
            press_start_reg <= '0;
            hold_reg        <= '0;
            last_click_reg  <= '0;
        end
        else if (accept)
        begin
            state_reg       <= state_next;
            tick_reg        <= tick_reg + TIME_W'(1);
            press_start_reg <= press_start_next;
            hold_reg        <= hold_next;
            last_click_reg  <= last_click_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bgc_queue.sv -----
// two-entry token queue between front and back
`default_nettype none

module bgc_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bgc_pkg::token_t   push_token,
    input  wire logic              pop,
    output bgc_pkg::token_t        pop_token,
    output bgc_pkg::q_status_t     status
);
    import bgc_pkg::*;

    token_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign pop_token    = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_token;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bgc_back.sv -----
// back end: pending event bits, priority dispatch and output register
`default_nettype none

module bgc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [3:0]        handler_enable,
    input  wire bgc_pkg::token_t   token,
    input  wire logic              q_empty,
    output logic                   pop,
    bgc_gesture_if.source          gesture
);
    import bgc_pkg::*;

    logic       out_valid_reg;
    logic       ev_valid_reg, ev_valid_next;
    kind_t      kind_reg, kind_next;
    logic [3:0] mask_reg;
    logic [3:0] pending_reg, pending_next;
    logic [3:0] pend_set;
    logic [3:0] ready_bits;

    // load a new beat when the output slot is free or being emptied
    assign pop = !q_empty && (!out_valid_reg || gesture.ready);

    always_comb
    begin
        pend_set = pending_reg;
        if (token.set_valid)
            pend_set[token.set_kind] = 1'b1;
        ready_bits    = pend_set & handler_enable;
        ev_valid_next = |ready_bits;
        kind_next     = KIND_CLICK;
        // lowest enabled pending bit wins
        for (int i = 3; i >= 0; i--)
        begin
            if (ready_bits[i])
                kind_next = kind_t'(i);
        end
        pending_next = pend_set;
        if (ev_valid_next)
            pending_next[kind_next] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pending_reg   <= '0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
            pending_reg   <= pending_next;
        end
        else if (gesture.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ev_valid_reg <= ev_valid_next;
            kind_reg     <= kind_next;
            mask_reg     <= pending_next;
        end
    end

    assign gesture.valid        = out_valid_reg;
    assign gesture.event_valid  = ev_valid_reg;
    assign gesture.event_kind   = kind_reg;
    assign gesture.pending_mask = mask_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/button_gesture_classifier.sv -----
// top level of the button gesture classifier
`default_nettype none

// Button gesture classifier. Each sample beat is one tick of the debounced
// button level; each beat yields exactly one gesture beat, in order, carrying
// the dispatched event (click, double click, long press, long-long press) and
// the pending bits left over. The block takes one sample per clock cycle
// when the gesture side keeps up; a gesture beat passes from its sample beat
// through the front state machine into the two-entry token queue, then
// through the dispatch stage into the output register.
// Sample ready depends only on the token queue having room, so a stalled
// gesture side backs up through the queue before the sample side stalls.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// should only be changed while no beats are in flight.
module button_gesture_classifier (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bgc_sample_if.sink                             sample,
    bgc_gesture_if.source                          gesture,
    input  wire logic                              cfg_we,
    input  wire logic [bgc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bgc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bgc_pkg::*;

`include "assert_macros.svh"

    cfg_t      cfg_reg;
    logic      push;
    token_t    push_token;
    logic      pop;
    token_t    pop_token;
    q_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLICK_MIN:      cfg_reg.click_min      <= cfg_data;
                REG_CLICK_MAX:      cfg_reg.click_max      <= cfg_data;
                REG_LONG_MIN:       cfg_reg.long_min       <= cfg_data;
                REG_LONG_MAX:       cfg_reg.long_max       <= cfg_data;
                REG_LONGER_MIN:     cfg_reg.longer_min     <= cfg_data;
                REG_LONGER_MAX:     cfg_reg.longer_max     <= cfg_data;
                REG_DOUBLE_WINDOW:  cfg_reg.double_window  <= cfg_data;
                REG_HANDLER_ENABLE: cfg_reg.handler_enable <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    bgc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .sample     (sample),
        .q_full     (q_status.full),
        .push       (push),
        .push_token (push_token)
    );

    bgc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .pop_token  (pop_token),
        .status     (q_status)
    );

    bgc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .handler_enable (cfg_reg.handler_enable),
        .token          (pop_token),
        .q_empty        (q_status.empty),
        .pop            (pop),
        .gesture        (gesture)
    );

    // a dispatched kind is always enabled and cleared from the pending bits
    `BGC_ASSERT_IMP(a_dispatch_enabled, clk, rst_n, gesture.valid && gesture.event_valid, cfg_reg.handler_enable[gesture.event_kind])
    `BGC_ASSERT_IMP(a_dispatch_cleared, clk, rst_n, gesture.valid && gesture.event_valid, !gesture.pending_mask[gesture.event_kind])
    // no dispatch reports kind click
    `BGC_ASSERT_IMP(a_idle_kind, clk, rst_n, gesture.valid && !gesture.event_valid, gesture.event_kind == KIND_CLICK)
    // a token pushed into an empty queue is there next cycle
    `BGC_ASSERT_NXT(a_queue_fill, clk, rst_n, push && q_status.empty, !q_status.empty)

endmodule

`default_nettype wire
